FILE: hw/rtl/aavr_pkg.sv
// Types, constants and the arctangent table for the axis-angle rotation pipeline.
package aavr_pkg;

    localparam int VEC_W  = 32;
    localparam int AXIS_W = 16;
    localparam int TURN_W = 16;
    localparam int WRAP_W = 36;
    localparam int ANG_W  = 34;
    localparam int ATAN_ENTRIES = 24;

    localparam logic signed [WRAP_W-1:0] PI_W     = 36'sd3373259426;
    localparam logic signed [WRAP_W-1:0] TWO_PI_W = 36'sd6746518852;
    localparam logic signed [ANG_W-1:0]  PI_A     = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0]  HALF_PI_A = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0]  GAIN_A   = 34'sd652032874;
    localparam logic signed [ANG_W:0]    ONE_T    = 35'sd1073741824;

    typedef struct packed {
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
        logic signed [TURN_W-1:0] turn_radians;
    } in_item_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] out_x;
        logic signed [VEC_W-1:0] out_y;
        logic signed [VEC_W-1:0] out_z;
        logic                    clipped;
    } out_item_t;

    // vector and axis riding alongside the angle work
    typedef struct packed {
        logic signed [VEC_W-1:0]  vec_x;
        logic signed [VEC_W-1:0]  vec_y;
        logic signed [VEC_W-1:0]  vec_z;
        logic signed [AXIS_W-1:0] axis_x;
        logic signed [AXIS_W-1:0] axis_y;
        logic signed [AXIS_W-1:0] axis_z;
    } carry_t;

    // atan(2^-i) in Q.30, truncated
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314856;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043836;
            5'd3:    v = 34'sd133525158;
            5'd4:    v = 34'sd67021686;
            5'd5:    v = 34'sd33543515;
            5'd6:    v = 34'sd16775850;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194282;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048575;
            5'd11:   v = 34'sd524287;
            5'd12:   v = 34'sd262143;
            5'd13:   v = 34'sd131071;
            5'd14:   v = 34'sd65535;
            5'd15:   v = 34'sd32767;
            5'd16:   v = 34'sd16383;
            5'd17:   v = 34'sd8191;
            5'd18:   v = 34'sd4095;
            5'd19:   v = 34'sd2047;
            5'd20:   v = 34'sd1023;
            5'd21:   v = 34'sd511;
            5'd22:   v = 34'sd255;
            5'd23:   v = 34'sd127;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: hw/rtl/aavr_ifs.sv
// Valid/ready stream interfaces for the input items and the result items.
interface aavr_in_if
    import aavr_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aavr_out_if
    import aavr_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/axis_angle_vector_rotate_top.sv
// Pipelined axis-angle (Rodrigues) rotation of a Q16.16 vector.
//
// feed:   one transfer carries vec_x/y/z (Q16.16), a unit axis (Q1.14) and the
//         angle turn_radians (Q4.12).
// result: one transfer per input, out_x/y/z in Q16.16 saturated, clipped set
//         when any component hit a rail.
// Throughput: one item per cycle while result.ready is high. Stages from the
// input transfer to result.valid: 2 angle reduction stages, one stage per
// CORDIC micro-rotation, then 6 stages of matrix build and multiply.
// Each stage holds its own valid bit; a stage loads when it is empty or when
// the stage after it moves, so bubbles are squeezed out under backpressure
// and feed.ready stays high while any stage has room.
// When result.ready is low the last stage holds its transfer; the pipeline
// fills behind it and feed.ready drops only when every stage is full.
// Reset (rst_n low, asynchronous) empties all stages; no data is lost or
// repeated across a stall.
module axis_angle_vector_rotate_top
    import aavr_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    aavr_in_if.sink      feed,
    aavr_out_if.source   result
);

    localparam int N      = CORDIC_STEPS;
    localparam int S_P1   = N + 2;
    localparam int S_P2   = N + 3;
    localparam int S_P3   = N + 4;
    localparam int S_P4   = N + 5;
    localparam int S_P5   = N + 6;
    localparam int S_P6   = N + 7;
    localparam int STAGES = N + 8;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] en;

    // stage handshake: load when empty or when the next stage moves
    assign en[STAGES-1] = !vld_reg[STAGES-1] || result.ready;
    for (genvar k = 0; k < STAGES - 1; k++)
    begin : g_en
        assign en[k] = !vld_reg[k] || en[k+1];
    end

    assign feed.ready   = en[0];
    assign result.valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= feed.valid;
            end
            for (int k = 1; k < STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // vector and axis travel with the item up to the vector multiply
    carry_t carry_reg [0:S_P3];

    // ---- stage 0: wrap the angle into [-pi, pi]
    logic signed [WRAP_W-1:0] ang_w_full;
    logic signed [WRAP_W-1:0] ang_w_next;
    logic signed [ANG_W-1:0]  ang_w_reg;

    assign ang_w_full = {{2{feed.data.turn_radians[TURN_W-1]}}, feed.data.turn_radians,
                         18'b0};

    always_comb
    begin
        if (ang_w_full > PI_W)
            ang_w_next = ang_w_full - TWO_PI_W;
        else if (ang_w_full < -PI_W)
            ang_w_next = ang_w_full + TWO_PI_W;
        else
            ang_w_next = ang_w_full;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ang_w_reg    <= ang_w_next[ANG_W-1:0];
            carry_reg[0] <= {feed.data.vec_x, feed.data.vec_y, feed.data.vec_z,
                             feed.data.axis_x, feed.data.axis_y, feed.data.axis_z};
        end
    end

    // ---- stage 1: fold into [-pi/2, pi/2], seed the CORDIC
    logic signed [ANG_W-1:0] cx_reg  [0:N];
    logic signed [ANG_W-1:0] cy_reg  [0:N];
    logic signed [ANG_W-1:0] ang_reg [0:N];
    logic                    flip_reg [0:N];

    logic signed [ANG_W-1:0] fold_next;
    logic                    flip_next;

    always_comb
    begin
        if (ang_w_reg > HALF_PI_A)
        begin
            fold_next = ang_w_reg - PI_A;
            flip_next = 1'b1;
        end
        else if (ang_w_reg < -HALF_PI_A)
        begin
            fold_next = ang_w_reg + PI_A;
            flip_next = 1'b1;
        end
        else
        begin
            fold_next = ang_w_reg;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            cx_reg[0]    <= GAIN_A;
            cy_reg[0]    <= '0;
            ang_reg[0]   <= fold_next;
            flip_reg[0]  <= flip_next;
            carry_reg[1] <= carry_reg[0];
        end
    end

    // ---- CORDIC micro-rotations, one per stage
    for (genvar j = 1; j <= N; j++)
    begin : g_cordic
        localparam int SHIFT = j - 1;
        logic signed [ANG_W-1:0] dx;
        logic signed [ANG_W-1:0] dy;
        logic signed [ANG_W-1:0] at;

        assign dx = cy_reg[j-1] >>> SHIFT;
        assign dy = cx_reg[j-1] >>> SHIFT;
        assign at = atan_entry(5'(SHIFT));

        always_ff @(posedge clk)
        begin
            if (en[j+1])
            begin
                if (ang_reg[j-1] >= 0)
                begin
                    cx_reg[j]  <= cx_reg[j-1] - dx;
                    cy_reg[j]  <= cy_reg[j-1] + dy;
                    ang_reg[j] <= ang_reg[j-1] - at;
                end
                else
                begin
                    cx_reg[j]  <= cx_reg[j-1] + dx;
                    cy_reg[j]  <= cy_reg[j-1] - dy;
                    ang_reg[j] <= ang_reg[j-1] + at;
                end
                flip_reg[j]    <= flip_reg[j-1];
                carry_reg[j+1] <= carry_reg[j];
            end
        end
    end

    // ---- P1: cos, sin, t = 1 - cos, axis products
    localparam int XX = 0;
    localparam int YY = 1;
    localparam int ZZ = 2;
    localparam int XY = 3;
    localparam int XZ = 4;
    localparam int YZ = 5;
    localparam int XS = 6;
    localparam int YS = 7;
    localparam int ZS = 8;

    logic signed [ANG_W-1:0] c_next;
    logic signed [ANG_W-1:0] c1_reg;
    logic signed [ANG_W-1:0] s1_reg;
    logic signed [ANG_W:0]   t1_reg;
    logic signed [31:0]      ab_next [0:5];
    logic signed [31:0]      ab_reg  [0:5];

    assign c_next = flip_reg[N] ? -cx_reg[N] : cx_reg[N];

    always_comb
    begin
        ab_next[XX] = 32'(carry_reg[N+1].axis_x) * 32'(carry_reg[N+1].axis_x);
        ab_next[YY] = 32'(carry_reg[N+1].axis_y) * 32'(carry_reg[N+1].axis_y);
        ab_next[ZZ] = 32'(carry_reg[N+1].axis_z) * 32'(carry_reg[N+1].axis_z);
        ab_next[XY] = 32'(carry_reg[N+1].axis_x) * 32'(carry_reg[N+1].axis_y);
        ab_next[XZ] = 32'(carry_reg[N+1].axis_x) * 32'(carry_reg[N+1].axis_z);
        ab_next[YZ] = 32'(carry_reg[N+1].axis_y) * 32'(carry_reg[N+1].axis_z);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_P1])
        begin
            c1_reg <= c_next;
            s1_reg <= flip_reg[N] ? -cy_reg[N] : cy_reg[N];
            t1_reg <= ONE_T - (ANG_W+1)'(c_next);
            for (int k = 0; k < 6; k++)
            begin
                ab_reg[k] <= ab_next[k];
            end
            carry_reg[S_P1] <= carry_reg[N+1];
        end
    end

    // ---- P2: a_i*a_j*t and a_k*sin, rounded to Q.30
    logic signed [66:0]      pt [0:5];
    logic signed [49:0]      ps [0:2];
    logic signed [66:0]      pt_rnd [0:5];
    logic signed [49:0]      ps_rnd [0:2];
    logic signed [35:0]      e_reg [0:8];
    logic signed [ANG_W-1:0] c2_reg;

    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            pt[k]     = 67'(ab_reg[k]) * 67'(t1_reg);
            pt_rnd[k] = (pt[k] + 67'sd134217728) >>> 28;
        end
        ps[0] = 50'(carry_reg[S_P1].axis_x) * 50'(s1_reg);
        ps[1] = 50'(carry_reg[S_P1].axis_y) * 50'(s1_reg);
        ps[2] = 50'(carry_reg[S_P1].axis_z) * 50'(s1_reg);
        for (int k = 0; k < 3; k++)
        begin
            ps_rnd[k] = (ps[k] + 50'sd8192) >>> 14;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_P2])
        begin
            for (int k = 0; k < 6; k++)
            begin
                e_reg[k] <= pt_rnd[k][35:0];
            end
            for (int k = 0; k < 3; k++)
            begin
                e_reg[XS+k] <= ps_rnd[k][35:0];
            end
            c2_reg          <= c1_reg;
            carry_reg[S_P2] <= carry_reg[S_P1];
        end
    end

    // ---- P3: rotation matrix entries, row major
    logic signed [36:0] m_reg [0:8];
    logic signed [36:0] cw;

    assign cw = 37'(c2_reg);

    always_ff @(posedge clk)
    begin
        if (en[S_P3])
        begin
            m_reg[0] <= 37'(e_reg[XX]) + cw;
            m_reg[1] <= 37'(e_reg[XY]) - 37'(e_reg[ZS]);
            m_reg[2] <= 37'(e_reg[XZ]) + 37'(e_reg[YS]);
            m_reg[3] <= 37'(e_reg[XY]) + 37'(e_reg[ZS]);
            m_reg[4] <= 37'(e_reg[YY]) + cw;
            m_reg[5] <= 37'(e_reg[YZ]) - 37'(e_reg[XS]);
            m_reg[6] <= 37'(e_reg[XZ]) - 37'(e_reg[YS]);
            m_reg[7] <= 37'(e_reg[YZ]) + 37'(e_reg[XS]);
            m_reg[8] <= 37'(e_reg[ZZ]) + cw;
            carry_reg[S_P3] <= carry_reg[S_P2];
        end
    end

    // ---- P4: entry times signed high and unsigned low halves of each component
    logic signed [VEC_W-1:0] vin [0:2];
    logic signed [52:0]      ph_next [0:8];
    logic signed [53:0]      pl_next [0:8];
    logic signed [52:0]      ph_reg [0:8];
    logic signed [53:0]      pl_reg [0:8];

    assign vin[0] = carry_reg[S_P3].vec_x;
    assign vin[1] = carry_reg[S_P3].vec_y;
    assign vin[2] = carry_reg[S_P3].vec_z;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ph_next[3*r+k] = 53'(m_reg[3*r+k]) * 53'($signed(vin[k][31:16]));
                pl_next[3*r+k] = 54'(m_reg[3*r+k]) * 54'($signed({1'b0, vin[k][15:0]}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_P4])
        begin
            for (int k = 0; k < 9; k++)
            begin
                ph_reg[k] <= ph_next[k];
                pl_reg[k] <= pl_next[k];
            end
        end
    end

    // ---- P5: row sums
    logic signed [54:0] hs_reg [0:2];
    logic signed [55:0] ls_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en[S_P5])
        begin
            for (int r = 0; r < 3; r++)
            begin
                hs_reg[r] <= 55'(ph_reg[3*r]) + 55'(ph_reg[3*r+1]) + 55'(ph_reg[3*r+2]);
                ls_reg[r] <= 56'(pl_reg[3*r]) + 56'(pl_reg[3*r+1]) + 56'(pl_reg[3*r+2]);
            end
        end
    end

    // ---- P6: combine halves, round to Q16.16, saturate
    logic signed [63:0]      sum64 [0:2];
    logic signed [63:0]      q16   [0:2];
    logic signed [VEC_W-1:0] sat   [0:2];
    logic [2:0]              clip;
    out_item_t               out_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum64[r] = 64'(hs_reg[r]) + ((64'(ls_reg[r]) + 64'sd536870912) >>> 16);
            q16[r]   = sum64[r] >>> 14;
            if (q16[r] > 64'sd2147483647)
            begin
                sat[r]  = 32'sh7FFFFFFF;
                clip[r] = 1'b1;
            end
            else if (q16[r] < -64'sd2147483648)
            begin
                sat[r]  = 32'sh80000000;
                clip[r] = 1'b1;
            end
            else
            begin
                sat[r]  = q16[r][VEC_W-1:0];
                clip[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[S_P6])
        begin
            out_reg.out_x   <= sat[0];
            out_reg.out_y   <= sat[1];
            out_reg.out_z   <= sat[2];
            out_reg.clipped <= |clip;
        end
    end

    assign result.data = out_reg;

`ifndef SYNTH
    a_accept_fills_stage0: assert property (@(posedge clk) disable iff (!rst_n)
        feed.valid && feed.ready |=> vld_reg[0])
        else $error("accepted transfer did not enter the first stage");

    a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (&vld_reg) && !result.ready |-> !feed.ready)
        else $error("input taken while every stage is full and output stalled");

    a_clip_means_rail: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.data.clipped |->
            result.data.out_x == 32'sh7FFFFFFF || result.data.out_x == 32'sh80000000 ||
            result.data.out_y == 32'sh7FFFFFFF || result.data.out_y == 32'sh80000000 ||
            result.data.out_z == 32'sh7FFFFFFF || result.data.out_z == 32'sh80000000)
        else $error("clipped set without a saturated component");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking testbench for the axis-angle vector rotation pipeline.
module tb;
    import aavr_pkg::*;

    localparam int STEPS       = 16;
    localparam int LATENCY     = STEPS + 8;
    localparam int RANDOM_ITEMS = 1500;
    localparam int STALL_LIMIT = 20000;

    // fixed-point constants of the rotation, Q.30
    localparam longint ONE_Q30   = 64'sd1073741824;
    localparam longint PI_Q30    = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518852;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint GAIN_Q30  = 64'sd652032874;
    localparam longint INT32_HI  = 64'sd2147483647;
    localparam longint INT32_LO  = -64'sd2147483648;
    localparam longint ATAN_TBL [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };

    logic clk;
    logic rst_n;

    aavr_in_if  feed ();
    aavr_out_if result ();

    axis_angle_vector_rotate_top #(
        .CORDIC_STEPS (STEPS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .feed   (feed.sink),
        .result (result.source)
    );

    // Directed row: the item, and an optional typed-in result. Rows without a
    // typed result are checked against the predictor only.
    typedef struct {
        in_item_t  item;
        bit        has_known;
        out_item_t known;
    } directed_row_t;

    out_item_t rotated_q[$];   // predicted rotations, oldest first
    int        fail_count;
    int        idle_cycles;
    bit        feeding_done;
    bit        hold_sender;    // sender waits for the result queue to drain

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Arithmetic shifts on longint are floor shifts, matching the pipeline.
    function automatic longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // One row of the matrix times the Q16.16 vector: split into high and low
    // halves so that nothing leaves 64 bits, round to Q16.16, then saturate.
    function automatic longint rotate_row(longint m0, longint m1, longint m2,
                                          longint v0, longint v1, longint v2,
                                          inout bit clip);
        longint hi;
        longint lo;
        longint r;
        hi = m0 * (v0 >>> 16) + m1 * (v1 >>> 16) + m2 * (v2 >>> 16);
        lo = m0 * (v0 & 64'hFFFF) + m1 * (v1 & 64'hFFFF) + m2 * (v2 & 64'hFFFF);
        r = (hi + ((lo + (64'sd1 <<< 29)) >>> 16)) >>> 14;
        if (r > INT32_HI)
        begin
            clip = 1'b1;
            r = INT32_HI;
        end
        else if (r < INT32_LO)
        begin
            clip = 1'b1;
            r = INT32_LO;
        end
        return r;
    endfunction

    function automatic out_item_t rotate_vector(in_item_t it);
        longint vx, vy, vz, ax, ay, az, ang, cx, cy, dx, dy, c, s, t;
        longint xx, yy, zz, xy, xz, yz, xs, ys, zs;
        longint ox, oy, oz;
        bit flip;
        bit clip;
        out_item_t o;
        vx = it.vec_x;  vy = it.vec_y;  vz = it.vec_z;
        ax = it.axis_x; ay = it.axis_y; az = it.axis_z;
        ang = longint'(it.turn_radians) * 262144;
        flip = 1'b0;
        clip = 1'b0;
        cx = GAIN_Q30;
        cy = 0;
        // wrap into [-pi, pi], then fold into [-pi/2, pi/2]
        if (ang > PI_Q30)
            ang -= TWO_PI_Q30;
        else if (ang < -PI_Q30)
            ang += TWO_PI_Q30;
        if (ang > HALF_PI_Q30)
        begin
            ang -= PI_Q30;
            flip = 1'b1;
        end
        else if (ang < -HALF_PI_Q30)
        begin
            ang += PI_Q30;
            flip = 1'b1;
        end
        for (int i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0)
            begin
                cx -= dx; cy += dy; ang -= ATAN_TBL[i];
            end
            else
            begin
                cx += dx; cy -= dy; ang += ATAN_TBL[i];
            end
        end
        c = flip ? -cx : cx;
        s = flip ? -cy : cy;
        t = ONE_Q30 - c;
        xx = round_shift(ax * ax * t, 28);
        yy = round_shift(ay * ay * t, 28);
        zz = round_shift(az * az * t, 28);
        xy = round_shift(ax * ay * t, 28);
        xz = round_shift(ax * az * t, 28);
        yz = round_shift(ay * az * t, 28);
        xs = round_shift(ax * s, 14);
        ys = round_shift(ay * s, 14);
        zs = round_shift(az * s, 14);
        ox = rotate_row(xx + c, xy - zs, xz + ys, vx, vy, vz, clip);
        oy = rotate_row(xy + zs, yy + c, yz - xs, vx, vy, vz, clip);
        oz = rotate_row(xz - ys, yz + xs, zz + c, vx, vy, vz, clip);
        o.out_x = ox[31:0];
        o.out_y = oy[31:0];
        o.out_z = oz[31:0];
        o.clipped = clip;
        return o;
    endfunction

    function automatic in_item_t make_item(int vx, int vy, int vz,
                                           shortint ax, shortint ay, shortint az,
                                           shortint ang);
        in_item_t it;
        it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
        it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
        it.turn_radians = ang;
        return it;
    endfunction

    function automatic out_item_t make_result(int x, int y, int z, bit clip);
        out_item_t o;
        o.out_x = x; o.out_y = y; o.out_z = z; o.clipped = clip;
        return o;
    endfunction

    // Mostly short gaps, now and then a long one, often none.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic shortint random_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return shortint'($urandom());          // full 16-bit range
        else if (r == 1)
            return ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
        return shortint'($urandom_range(0, 32768)) - 16'sd16384;
    endfunction

    function automatic int random_vec();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
        else if (r < 7)
            return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        return int'($urandom());
    endfunction

    // one transfer on the feed side, with a random lead-in gap; entered and
    // left at a falling edge, valid stays high when the next item follows
    task automatic send_item(in_item_t it);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            feed.valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        feed.data  <= it;
        feed.valid <= 1'b1;
        @(posedge clk);
        while (!feed.ready)
            @(posedge clk);
        rotated_q.push_back(rotate_vector(it));
        @(negedge clk);
    endtask

    directed_row_t directed_rows[$];

    // Stimulus
    initial
    begin
        directed_row_t row_v;
        in_item_t it;
        int n_dir;
        shortint angs [8];
        rst_n        = 1'b0;
        feed.valid   = 1'b0;
        feed.data    = '0;
        feeding_done = 1'b0;
        hold_sender  = 1'b0;

        // zero angle about z is identity; zero vector gives zero
        row_v.has_known = 1'b1;
        row_v.item  = make_item(0, 0, 0, 16384, 0, 0, 0);
        row_v.known = make_result(0, 0, 0, 1'b0);
        directed_rows.push_back(row_v);
        row_v.item  = make_item(32'h0001_0000, 0, 0, 0, 0, 16384, 0);
        row_v.known = rotate_vector(row_v.item);
        row_v.has_known = 1'b0;
        directed_rows.push_back(row_v);
        // angle extremes: most positive, most negative, beyond pi, beyond pi/2
        angs = '{16'sh7FFF, 16'sh8000, 16'sd12868, -16'sd12868,
                 16'sd6434, -16'sd6434, 16'sd12869, 16'sd6435};
        for (int k = 0; k < 8; k++)
        begin
            row_v.item = make_item(32'h0001_0000, 32'h0002_0000, -32'h0003_0000,
                                   (k % 3 == 0) ? 16'sd16384 : 16'sd0,
                                   (k % 3 == 1) ? -16'sd16384 : 16'sd0,
                                   (k % 3 == 2) ? 16'sd16384 : 16'sd0, angs[k]);
            directed_rows.push_back(row_v);
        end
        // vector extremes: saturation under a half turn
        row_v.item = make_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               16'sd16384, 16'sd0, 16'sd0, 16'sd12868);
        directed_rows.push_back(row_v);
        row_v.item = make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               16'sd9459, 16'sd9459, 16'sd9459, 16'sd3217);
        directed_rows.push_back(row_v);
        // axis not unit length, and axis at the extremes of 16 bits
        row_v.item = make_item(32'h0010_0000, -32'h0010_0000, 32'h0000_8000,
                               16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sd4096);
        directed_rows.push_back(row_v);
        row_v.item = make_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        directed_rows.push_back(row_v);
        row_v.item = make_item(32'h0000_0001, -32'sd1, 32'h0000_FFFF,
                               16'sd0, 16'sd0, 16'sd0, 16'sd1000);
        directed_rows.push_back(row_v);
        row_v.item = make_item(32'h0001_0000, 0, 0, 16'sd0, 16'sd0, 16'sd16384, 16'sh8001);
        directed_rows.push_back(row_v);

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        n_dir = directed_rows.size();
        for (int k = 0; k < n_dir; k++)
        begin
            if (directed_rows[k].has_known && rotate_vector(directed_rows[k].item)
                    != directed_rows[k].known)
            begin
                $display("%0t: directed row %0d: expected %h predicted %h", $time, k,
                         directed_rows[k].known, rotate_vector(directed_rows[k].item));
                fail_count++;
            end
            send_item(directed_rows[k].item);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            // once midway the sender stands back until the pipeline drains
            if (k == RANDOM_ITEMS / 2)
            begin
                hold_sender = 1'b1;
                feed.valid <= 1'b0;
                @(negedge clk);
                while (rotated_q.size() != 0)
                    @(negedge clk);
                hold_sender = 1'b0;
            end
            it = make_item(random_vec(), random_vec(), random_vec(),
                           random_axis(), random_axis(), random_axis(),
                           shortint'($urandom()));
            send_item(it);
        end
        feed.valid <= 1'b0;
        feeding_done = 1'b1;
    end

    // Result side: random backpressure, checking at the rising edge.
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                stall--;
            end
            else
            begin
                result.ready <= 1'b1;
                stall = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result.valid && result.ready)
        begin
            if (rotated_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, result.data);
                fail_count++;
            end
            else
            begin
                want = rotated_q.pop_front();
                if (result.data.out_x !== want.out_x)
                begin
                    $display("%0t: out_x expected %h actual %h", $time, want.out_x,
                             result.data.out_x);
                    fail_count++;
                end
                if (result.data.out_y !== want.out_y)
                begin
                    $display("%0t: out_y expected %h actual %h", $time, want.out_y,
                             result.data.out_y);
                    fail_count++;
                end
                if (result.data.out_z !== want.out_z)
                begin
                    $display("%0t: out_z expected %h actual %h", $time, want.out_z,
                             result.data.out_z);
                    fail_count++;
                end
                if (result.data.clipped !== want.clipped)
                begin
                    $display("%0t: clipped expected %b actual %b", $time, want.clipped,
                             result.data.clipped);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on either side, and the end of run.
    initial
    begin
        bit timed_out;
        timed_out = 1'b0;
        @(posedge rst_n);
        while (!(feeding_done && rotated_q.size() == 0) && !timed_out)
        begin
            @(posedge clk);
            if ((feed.valid && feed.ready) || (result.valid && result.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
                timed_out = 1'b1;
        end
        if (timed_out)
        begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("CHECKS FAILED");
        end
        else
        begin
            // late strays would show up as unexpected results
            repeat (LATENCY * 4)
                @(posedge clk);
            if (fail_count == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/aavr_pkg.sv
hw/rtl/aavr_ifs.sv
hw/rtl/axis_angle_vector_rotate_top.sv
tb/tb.sv
